@@ rtl/bpm_pkg.sv @@
`default_nettype none

package bpm_pkg;

   localparam int COORD_WIDTH_DEFAULT = 16;

   localparam int AREA_W = 32;
   localparam int DIST_W = 17;
   localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};
   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

   localparam int SQ_W   = 2 * DIST_W;
   localparam int SUM_W  = SQ_W + 1;
   localparam int ROOT_W = DIST_W + 1;
   localparam int RAD_W  = 2 * ROOT_W;
   localparam int REM_W  = ROOT_W + 2;
   localparam int SQRT_STEPS = ROOT_W;

   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic box_invalid;
      logic contained;
      logic dist_sat;
   } flags_type;

endpackage

`default_nettype wire

@@ rtl/box_point_metrics.sv @@
// Box and point metrics. The block takes one box and one point per clock
// cycle (start high while busy is low) and returns one result beat for
// each, on the rsp_ ports for a single cycle marked by rsp_valid; results
// leave in order. The receiver cannot stall the block, so the back end
// never holds and busy stays low in steady operation. The square root
// resolves one bit of the distance per pipeline stage over 18 stages.
// Ahead of it sit the classifying front register, a four-entry queue, a
// multiplier stage and a stage that forms the area difference and the sum
// of squares; an output register follows it.
`default_nettype none

module box_point_metrics #(
   parameter int COORD_WIDTH = bpm_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [COORD_WIDTH-1:0]     req_box_min_x,
   input  logic signed [COORD_WIDTH-1:0]     req_box_min_y,
   input  logic signed [COORD_WIDTH-1:0]     req_box_max_x,
   input  logic signed [COORD_WIDTH-1:0]     req_box_max_y,
   input  logic signed [COORD_WIDTH-1:0]     req_point_x,
   input  logic signed [COORD_WIDTH-1:0]     req_point_y,
   output logic                              rsp_valid,
   output logic                              rsp_contained,
   output logic [bpm_pkg::AREA_W-1:0]        rsp_enlargement_area,
   output logic [bpm_pkg::DIST_W-1:0]        rsp_distance,
   output logic                              rsp_box_invalid
);

   localparam int DATA_W  = 4 * COORD_WIDTH + 2 * bpm_pkg::DIST_W;
   localparam int FLAGS_W = $bits(bpm_pkg::flags_type);
   localparam int QUEUE_W = FLAGS_W + DATA_W;

   logic               front_valid, queue_ready, back_valid;
   bpm_pkg::flags_type front_flags, back_flags;
   logic [DATA_W-1:0]  front_data, back_data;
   logic [QUEUE_W-1:0] queue_out;

   bpm_front #(
      .COORD_WIDTH (COORD_WIDTH),
      .DATA_W      (DATA_W)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_box_min_x (req_box_min_x),
      .req_box_min_y (req_box_min_y),
      .req_box_max_x (req_box_max_x),
      .req_box_max_y (req_box_max_y),
      .req_point_x   (req_point_x),
      .req_point_y   (req_point_y),
      .queue_ready   (queue_ready),
      .item_valid    (front_valid),
      .item_flags    (front_flags),
      .item_data     (front_data)
   );

   bpm_queue #(
      .WIDTH (QUEUE_W),
      .DEPTH (bpm_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (queue_ready),
      .push_data  ({front_flags, front_data}),
      .pop_valid  (back_valid),
      .pop_data   (queue_out)
   );

   assign back_flags = queue_out[QUEUE_W-1 -: FLAGS_W];
   assign back_data  = queue_out[DATA_W-1:0];

   bpm_back #(
      .COORD_WIDTH (COORD_WIDTH),
      .DATA_W      (DATA_W)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .item_valid           (back_valid),
      .item_flags           (back_flags),
      .item_data            (back_data),
      .rsp_valid            (rsp_valid),
      .rsp_contained        (rsp_contained),
      .rsp_enlargement_area (rsp_enlargement_area),
      .rsp_distance         (rsp_distance),
      .rsp_box_invalid      (rsp_box_invalid)
   );

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_box_invalid |->
         !rsp_contained && rsp_enlargement_area == '0 && rsp_distance == '0)
      else $error("invalid box result carries non-zero fields");

   a_inside_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_contained |->
         rsp_enlargement_area == '0 && rsp_distance == '0 && !rsp_box_invalid)
      else $error("contained point reports growth or distance");

   a_zero_dist_inside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_box_invalid && rsp_distance == '0 |-> rsp_contained)
      else $error("zero distance without containment");

   a_reset_quiet: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result beat straight after reset");

endmodule

`default_nettype wire

@@ rtl/bpm_front.sv @@
`default_nettype none

module bpm_front #(
   parameter int COORD_WIDTH = bpm_pkg::COORD_WIDTH_DEFAULT,
   parameter int DATA_W      = 4 * COORD_WIDTH + 2 * bpm_pkg::DIST_W
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_box_min_x,
   input  logic signed [COORD_WIDTH-1:0] req_box_min_y,
   input  logic signed [COORD_WIDTH-1:0] req_box_max_x,
   input  logic signed [COORD_WIDTH-1:0] req_box_max_y,
   input  logic signed [COORD_WIDTH-1:0] req_point_x,
   input  logic signed [COORD_WIDTH-1:0] req_point_y,
   input  logic                          queue_ready,
   output logic                          item_valid,
   output bpm_pkg::flags_type            item_flags,
   output logic [DATA_W-1:0]             item_data
);

   localparam int W1    = COORD_WIDTH + 1;
   localparam int EXT_W = COORD_WIDTH + bpm_pkg::DIST_W;

   logic                  valid_ff, valid_in;
   bpm_pkg::flags_type    flags_ff, flags_in;
   logic [DATA_W-1:0]     data_ff, data_in;
   logic                  accept;

   logic signed [W1-1:0]  x0, y0, x1, y1, px, py;
   logic                  lo_x, hi_x, lo_y, hi_y, invalid;
   logic signed [W1-1:0]  dx_full, dy_full, gx0, gx1, gy0, gy1;
   logic signed [W1-1:0]  span_x_full, span_y_full, grow_x_full, grow_y_full;
   logic [EXT_W-1:0]      dx_ext, dy_ext, dist_max_ext;

   assign busy   = valid_ff && !queue_ready;
   assign accept = start && !busy;

   always_comb begin
      x0 = {req_box_min_x[COORD_WIDTH-1], req_box_min_x};
      y0 = {req_box_min_y[COORD_WIDTH-1], req_box_min_y};
      x1 = {req_box_max_x[COORD_WIDTH-1], req_box_max_x};
      y1 = {req_box_max_y[COORD_WIDTH-1], req_box_max_y};
      px = {req_point_x[COORD_WIDTH-1], req_point_x};
      py = {req_point_y[COORD_WIDTH-1], req_point_y};

      invalid = (x0 > x1) || (y0 > y1);
      lo_x = px < x0;
      hi_x = px > x1;
      lo_y = py < y0;
      hi_y = py > y1;

      dx_full = lo_x ? (x0 - px) : (hi_x ? (px - x1) : '0);
      dy_full = lo_y ? (y0 - py) : (hi_y ? (py - y1) : '0);
      gx0 = lo_x ? px : x0;
      gx1 = hi_x ? px : x1;
      gy0 = lo_y ? py : y0;
      gy1 = hi_y ? py : y1;

      span_x_full = x1 - x0;
      span_y_full = y1 - y0;
      grow_x_full = gx1 - gx0;
      grow_y_full = gy1 - gy0;

      dx_ext = {{bpm_pkg::DIST_W{1'b0}}, dx_full[COORD_WIDTH-1:0]};
      dy_ext = {{bpm_pkg::DIST_W{1'b0}}, dy_full[COORD_WIDTH-1:0]};
      dist_max_ext = {{COORD_WIDTH{1'b0}}, bpm_pkg::DIST_MAX};

      flags_in.box_invalid = invalid;
      flags_in.contained   = !invalid && !lo_x && !hi_x && !lo_y && !hi_y;
      flags_in.dist_sat    = (dx_ext > dist_max_ext) || (dy_ext > dist_max_ext);

      data_in = {span_x_full[COORD_WIDTH-1:0], span_y_full[COORD_WIDTH-1:0],
                 grow_x_full[COORD_WIDTH-1:0], grow_y_full[COORD_WIDTH-1:0],
                 dx_ext[bpm_pkg::DIST_W-1:0], dy_ext[bpm_pkg::DIST_W-1:0]};

      if (accept) begin
         valid_in = 1'b1;
      end else if (queue_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         flags_ff <= flags_in;
         data_ff  <= data_in;
      end
   end

   assign item_valid = valid_ff;
   assign item_flags = flags_ff;
   assign item_data  = data_ff;

endmodule

`default_nettype wire

@@ rtl/bpm_queue.sv @@
`default_nettype none

module bpm_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = bpm_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   logic [WIDTH-1:0] entry_ff [0:DEPTH-1];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ rtl/bpm_back.sv @@
`default_nettype none

module bpm_back #(
   parameter int COORD_WIDTH = bpm_pkg::COORD_WIDTH_DEFAULT,
   parameter int DATA_W      = 4 * COORD_WIDTH + 2 * bpm_pkg::DIST_W
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              item_valid,
   input  bpm_pkg::flags_type                item_flags,
   input  logic [DATA_W-1:0]                 item_data,
   output logic                              rsp_valid,
   output logic                              rsp_contained,
   output logic [bpm_pkg::AREA_W-1:0]        rsp_enlargement_area,
   output logic [bpm_pkg::DIST_W-1:0]        rsp_distance,
   output logic                              rsp_box_invalid
);

   localparam int W      = COORD_WIDTH;
   localparam int PROD_W = 2 * W;
   localparam int DW     = bpm_pkg::DIST_W;
   localparam int AW     = bpm_pkg::AREA_W;
   localparam int STEPS  = bpm_pkg::SQRT_STEPS;
   localparam int REM_W  = bpm_pkg::REM_W;
   localparam int ROOT_W = bpm_pkg::ROOT_W;
   localparam int RAD_W  = bpm_pkg::RAD_W;
   localparam int SUM_W  = bpm_pkg::SUM_W;
   localparam int SQ_W   = bpm_pkg::SQ_W;

   logic [W-1:0]  span_x, span_y, grow_x, grow_y;
   logic [DW-1:0] dx, dy;

   assign {span_x, span_y, grow_x, grow_y, dx, dy} = item_data;

   // Products.
   logic               m_valid_ff;
   bpm_pkg::flags_type m_flags_ff;
   logic [PROD_W-1:0]  m_area0_ff, m_area1_ff;
   logic [SQ_W-1:0]    m_sqx_ff, m_sqy_ff;

   // Area difference and sum of squares.
   logic [PROD_W-1:0]    diff;
   logic [PROD_W+AW-1:0] diff_ext, area_max_ext;
   logic [AW-1:0]        grow_sat;
   logic [SUM_W-1:0]     sum_sq;

   // Square root stages, one result bit each.
   logic               sv_valid_ff [0:STEPS];
   bpm_pkg::flags_type sv_flags_ff [0:STEPS];
   logic [AW-1:0]      sv_grow_ff  [0:STEPS];
   logic [REM_W-1:0]   sv_rem_ff   [0:STEPS];
   logic [ROOT_W-1:0]  sv_root_ff  [0:STEPS];
   logic [RAD_W-1:0]   sv_rad_ff   [0:STEPS];
   logic [REM_W-1:0]   sv_rem_in   [1:STEPS];
   logic [ROOT_W-1:0]  sv_root_in  [1:STEPS];
   logic [RAD_W-1:0]   sv_rad_in   [1:STEPS];

   logic               out_valid_ff, out_contained_ff, out_invalid_ff;
   logic [AW-1:0]      out_area_ff, out_area_in;
   logic [DW-1:0]      out_dist_ff, out_dist_in;
   bpm_pkg::flags_type last_flags;
   logic [ROOT_W-1:0]  last_root;

   always_comb begin
      diff         = m_area1_ff - m_area0_ff;
      diff_ext     = {{AW{1'b0}}, diff};
      area_max_ext = {{PROD_W{1'b0}}, bpm_pkg::AREA_MAX};
      grow_sat     = (diff_ext > area_max_ext) ? bpm_pkg::AREA_MAX : diff_ext[AW-1:0];
      sum_sq       = {1'b0, m_sqx_ff} + {1'b0, m_sqy_ff};
   end

   always_comb begin
      logic [REM_W-1:0] shifted;
      logic [REM_W-1:0] trial;
      logic             take;
      for (int k = 0; k < STEPS; k++) begin
         shifted = {sv_rem_ff[k][REM_W-3:0], sv_rad_ff[k][RAD_W-1 -: 2]};
         trial   = {sv_root_ff[k], 2'b01};
         take    = shifted >= trial;
         sv_rem_in[k+1]  = take ? (shifted - trial) : shifted;
         sv_root_in[k+1] = {sv_root_ff[k][ROOT_W-2:0], take};
         sv_rad_in[k+1]  = {sv_rad_ff[k][RAD_W-3:0], 2'b00};
      end
   end

   always_comb begin
      last_flags = sv_flags_ff[STEPS];
      last_root  = sv_root_ff[STEPS];
      if (last_flags.box_invalid) begin
         out_area_in = '0;
         out_dist_in = '0;
      end else begin
         out_area_in = sv_grow_ff[STEPS];
         if (last_flags.dist_sat || last_root[ROOT_W-1]) begin
            out_dist_in = bpm_pkg::DIST_MAX;
         end else begin
            out_dist_in = last_root[DW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int k = 0; k <= STEPS; k++) begin
            sv_valid_ff[k] <= 1'b0;
         end
      end else begin
         m_valid_ff     <= item_valid;
         sv_valid_ff[0] <= m_valid_ff;
         for (int k = 0; k < STEPS; k++) begin
            sv_valid_ff[k+1] <= sv_valid_ff[k];
         end
         out_valid_ff <= sv_valid_ff[STEPS];
      end

      m_flags_ff <= item_flags;
      m_area0_ff <= PROD_W'(span_x * span_y);
      m_area1_ff <= PROD_W'(grow_x * grow_y);
      m_sqx_ff   <= SQ_W'(dx * dx);
      m_sqy_ff   <= SQ_W'(dy * dy);

      sv_flags_ff[0] <= m_flags_ff;
      sv_grow_ff[0]  <= grow_sat;
      sv_rem_ff[0]   <= '0;
      sv_root_ff[0]  <= '0;
      sv_rad_ff[0]   <= {{(RAD_W-SUM_W){1'b0}}, sum_sq};
      for (int k = 0; k < STEPS; k++) begin
         sv_flags_ff[k+1] <= sv_flags_ff[k];
         sv_grow_ff[k+1]  <= sv_grow_ff[k];
         sv_rem_ff[k+1]   <= sv_rem_in[k+1];
         sv_root_ff[k+1]  <= sv_root_in[k+1];
         sv_rad_ff[k+1]   <= sv_rad_in[k+1];
      end

      out_contained_ff <= last_flags.contained;
      out_invalid_ff   <= last_flags.box_invalid;
      out_area_ff      <= out_area_in;
      out_dist_ff      <= out_dist_in;
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_contained        = out_contained_ff;
   assign rsp_enlargement_area = out_area_ff;
   assign rsp_distance         = out_dist_ff;
   assign rsp_box_invalid      = out_invalid_ff;

endmodule

`default_nettype wire

@@ verif/box_point_metrics_test.sv @@
`default_nettype none

module box_point_metrics_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW           = bpm_pkg::COORD_WIDTH_DEFAULT;
   localparam int AW           = bpm_pkg::AREA_W;
   localparam int DW           = bpm_pkg::DIST_W;
   localparam int RANDOM_ITEMS = 1030;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 40;

   typedef logic signed [CW-1:0] coord_type;

   typedef struct {
      logic          contained;
      logic [AW-1:0] area;
      logic [DW-1:0] distance;
      logic          invalid;
   } metrics_type;

   typedef struct {
      coord_type   min_x;
      coord_type   min_y;
      coord_type   max_x;
      coord_type   max_y;
      coord_type   pt_x;
      coord_type   pt_y;
      logic        typed;
      metrics_type want;
   } box_row_type;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      start = 1'b0;
   coord_type req_box_min_x = '0;
   coord_type req_box_min_y = '0;
   coord_type req_box_max_x = '0;
   coord_type req_box_max_y = '0;
   coord_type req_point_x   = '0;
   coord_type req_point_y   = '0;

   logic          busy;
   logic          rsp_valid;
   logic          rsp_contained;
   logic [AW-1:0] rsp_enlargement_area;
   logic [DW-1:0] rsp_distance;
   logic          rsp_box_invalid;

   metrics_type pending_want;
   metrics_type expected_metrics [$];
   box_row_type directed_rows [$];
   int          accepted_beats = 0;
   int          idle_cycles    = 0;
   int          error_count    = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   box_point_metrics DUT (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_box_min_x        (req_box_min_x),
      .req_box_min_y        (req_box_min_y),
      .req_box_max_x        (req_box_max_x),
      .req_box_max_y        (req_box_max_y),
      .req_point_x          (req_point_x),
      .req_point_y          (req_point_y),
      .rsp_valid            (rsp_valid),
      .rsp_contained        (rsp_contained),
      .rsp_enlargement_area (rsp_enlargement_area),
      .rsp_distance         (rsp_distance),
      .rsp_box_invalid      (rsp_box_invalid)
   );

   function automatic logic [63:0] floor_root(logic [63:0] value);
      logic [63:0] rest;
      logic [63:0] root;
      logic [63:0] step;
      rest = value;
      root = '0;
      step = 64'h1 << 62;
      while (step > rest)
         step >>= 2;
      while (step != 0) begin
         if (rest >= root + step) begin
            rest = rest - (root + step);
            root = (root >> 1) + step;
         end else begin
            root >>= 1;
         end
         step >>= 2;
      end
      return root;
   endfunction

   function automatic metrics_type predict_metrics(coord_type x0, coord_type y0,
                                                   coord_type x1, coord_type y1,
                                                   coord_type px, coord_type py);
      longint      lx0, ly0, lx1, ly1, lpx, lpy;
      longint      gx0, gy0, gx1, gy1;
      longint      dx, dy;
      longint      grow;
      logic [63:0] root;
      metrics_type m;
      m.contained = 1'b0;
      m.area      = '0;
      m.distance  = '0;
      m.invalid   = 1'b0;
      lx0 = longint'(x0);
      ly0 = longint'(y0);
      lx1 = longint'(x1);
      ly1 = longint'(y1);
      lpx = longint'(px);
      lpy = longint'(py);
      if (lx0 > lx1 || ly0 > ly1) begin
         m.invalid = 1'b1;
         return m;
      end
      gx0 = lx0;
      gy0 = ly0;
      gx1 = lx1;
      gy1 = ly1;
      dx  = 0;
      dy  = 0;
      if (lpx < lx0) begin
         dx  = lx0 - lpx;
         gx0 = lpx;
      end
      if (lpx > lx1) begin
         dx  = lpx - lx1;
         gx1 = lpx;
      end
      if (lpy < ly0) begin
         dy  = ly0 - lpy;
         gy0 = lpy;
      end
      if (lpy > ly1) begin
         dy  = lpy - ly1;
         gy1 = lpy;
      end
      m.contained = (dx == 0 && dy == 0);
      grow = (gx1 - gx0) * (gy1 - gy0) - (lx1 - lx0) * (ly1 - ly0);
      m.area = (grow > longint'(bpm_pkg::AREA_MAX)) ? bpm_pkg::AREA_MAX : grow[AW-1:0];
      if (dx > longint'(bpm_pkg::DIST_MAX) || dy > longint'(bpm_pkg::DIST_MAX)) begin
         m.distance = bpm_pkg::DIST_MAX;
      end else begin
         root = floor_root(64'(dx * dx + dy * dy));
         m.distance = (root > 64'(bpm_pkg::DIST_MAX)) ? bpm_pkg::DIST_MAX : root[DW-1:0];
      end
      return m;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      metrics_type w;
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if (start && !busy) begin
            expected_metrics.push_back(pending_want);
            accepted_beats++;
         end
         if (rsp_valid) begin
            if (expected_metrics.size() == 0) begin
               report_mismatch("result beat with nothing outstanding", 64'd1, 64'd0);
            end else begin
               w = expected_metrics.pop_front();
               if (rsp_contained !== w.contained)
                  report_mismatch("contained", 64'(rsp_contained), 64'(w.contained));
               if (rsp_enlargement_area !== w.area)
                  report_mismatch("enlargement_area", 64'(rsp_enlargement_area),
                                  64'(w.area));
               if (rsp_distance !== w.distance)
                  report_mismatch("distance", 64'(rsp_distance), 64'(w.distance));
               if (rsp_box_invalid !== w.invalid)
                  report_mismatch("box_invalid", 64'(rsp_box_invalid), 64'(w.invalid));
            end
         end
         if ((start && !busy) || rsp_valid)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
   end

   initial begin
      while (idle_cycles < STALL_LIMIT)
         @(negedge clock);
      $display("TB_ERROR");
      $finish;
   end

   task automatic add_row(int x0, int y0, int x1, int y1, int px, int py, int typed,
                          int c, longint a, int d, int inv);
      box_row_type r;
      r.min_x = coord_type'(x0);
      r.min_y = coord_type'(y0);
      r.max_x = coord_type'(x1);
      r.max_y = coord_type'(y1);
      r.pt_x  = coord_type'(px);
      r.pt_y  = coord_type'(py);
      r.typed = (typed != 0);
      if (r.typed) begin
         r.want.contained = (c != 0);
         r.want.area      = AW'(a);
         r.want.distance  = DW'(d);
         r.want.invalid   = (inv != 0);
      end else begin
         r.want = predict_metrics(r.min_x, r.min_y, r.max_x, r.max_y, r.pt_x, r.pt_y);
      end
      directed_rows.push_back(r);
   endtask

   function automatic coord_type random_coord();
      case ($urandom_range(0, 15))
         0:       return coord_type'(-32768);
         1:       return coord_type'(32767);
         2:       return coord_type'(0);
         3:       return coord_type'(-1);
         default: return coord_type'($urandom);
      endcase
   endfunction

   function automatic box_row_type random_row();
      box_row_type r;
      coord_type   a, b, c, d, t;
      int          lo, hi;
      if ($urandom_range(0, 9) == 0) begin
         r.min_x = random_coord();
         r.min_y = random_coord();
         r.max_x = random_coord();
         r.max_y = random_coord();
         r.pt_x  = random_coord();
         r.pt_y  = random_coord();
      end else begin
         a = random_coord();
         c = random_coord();
         if ($urandom_range(0, 2) == 0) begin
            b = coord_type'(int'(a) + int'($urandom_range(0, 40)));
            d = coord_type'(int'(c) + int'($urandom_range(0, 40)));
         end else begin
            b = random_coord();
            d = random_coord();
         end
         if (a > b) begin
            t = a;
            a = b;
            b = t;
         end
         if (c > d) begin
            t = c;
            c = d;
            d = t;
         end
         r.min_x = a;
         r.max_x = b;
         r.min_y = c;
         r.max_y = d;
         case ($urandom_range(0, 3))
            0: begin
               r.pt_x = random_coord();
               r.pt_y = random_coord();
            end
            1: begin
               lo = int'(a);
               hi = int'(b);
               r.pt_x = coord_type'(lo + int'($urandom_range(0, hi - lo)));
               lo = int'(c);
               hi = int'(d);
               r.pt_y = coord_type'(lo + int'($urandom_range(0, hi - lo)));
            end
            2: begin
               lo = int'($urandom_range(0, 1) ? a : b);
               r.pt_x = coord_type'(lo + int'($urandom_range(0, 6)) - 3);
               lo = int'($urandom_range(0, 1) ? c : d);
               r.pt_y = coord_type'(lo + int'($urandom_range(0, 6)) - 3);
            end
            default: begin
               r.pt_x = $urandom_range(0, 1) ? coord_type'(-32768) : coord_type'(32767);
               r.pt_y = $urandom_range(0, 1) ? coord_type'(-32768) : coord_type'(32767);
            end
         endcase
      end
      r.typed = 1'b0;
      r.want  = predict_metrics(r.min_x, r.min_y, r.max_x, r.max_y, r.pt_x, r.pt_y);
      return r;
   endfunction

   // Called at a falling edge; returns at the falling edge after the beat is taken,
   // with start still high so that a following beat may go out without a gap.
   task automatic send_beat(box_row_type r, int gap);
      int seen;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_box_min_x <= r.min_x;
      req_box_min_y <= r.min_y;
      req_box_max_x <= r.max_x;
      req_box_max_y <= r.max_y;
      req_point_x   <= r.pt_x;
      req_point_y   <= r.pt_y;
      pending_want  <= r.want;
      start         <= 1'b1;
      seen = accepted_beats;
      @(negedge clock);
      while (accepted_beats == seen)
         @(negedge clock);
   endtask

   task automatic pause_until_drained();
      start <= 1'b0;
      while (expected_metrics.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      int gap;
      add_row(0, 0, 10, 10, 5, 5, 1, 1, 0, 0, 0);
      add_row(0, 0, 10, 10, 0, 0, 1, 1, 0, 0, 0);
      add_row(0, 0, 10, 10, 10, 10, 1, 1, 0, 0, 0);
      add_row(0, 0, 10, 10, -3, 5, 1, 0, 30, 3, 0);
      add_row(0, 0, 10, 10, 14, 5, 0, 0, 0, 0, 0);
      add_row(0, 0, 10, 10, 5, -7, 0, 0, 0, 0, 0);
      add_row(0, 0, 10, 10, 5, 20, 0, 0, 0, 0, 0);
      add_row(0, 0, 10, 10, 13, 14, 1, 0, 82, 5, 0);
      add_row(0, 0, 10, 10, -1, -1, 0, 0, 0, 0, 0);
      add_row(0, 0, 10, 10, 11, 11, 0, 0, 0, 0, 0);
      add_row(7, 7, 7, 7, 7, 7, 1, 1, 0, 0, 0);
      add_row(5, 0, 4, 10, 0, 0, 1, 0, 0, 0, 1);
      add_row(0, 5, 10, 4, 0, 0, 1, 0, 0, 0, 1);
      add_row(5, 5, 4, 4, 4, 4, 1, 0, 0, 0, 1);
      add_row(32767, 32767, -32768, -32768, 0, 0, 1, 0, 0, 0, 1);
      add_row(-32768, -32768, -32768, -32768, 32767, 32767, 1, 0, 4294836225,
              92680, 0);
      add_row(32767, 32767, 32767, 32767, -32768, -32768, 1, 0, 4294836225,
              92680, 0);
      add_row(-32768, -32768, 32767, 32767, -32768, 32767, 1, 1, 0, 0, 0);
      add_row(-32768, 0, 32767, 0, 0, 32767, 0, 0, 0, 0, 0);
      add_row(-32768, 0, 32767, 0, 0, -32768, 0, 0, 0, 0, 0);
      add_row(-1, -1, 0, 0, -32768, 32767, 0, 0, 0, 0, 0);
      add_row(-32768, -32768, 32767, 32767, 32767, -32768, 1, 1, 0, 0, 0);

      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i])
         send_beat(directed_rows[i],
                   ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 16)));
      pause_until_drained();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 2)
            pause_until_drained();
         if ((i / 60) % 4 == 1)
            gap = 0;
         else
            gap = int'($urandom_range(0, 16));
         send_beat(random_row(), gap);
      end

      start <= 1'b0;
      while (expected_metrics.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

`default_nettype wire

@@ files.f @@
rtl/bpm_pkg.sv
rtl/bpm_front.sv
rtl/bpm_queue.sv
rtl/bpm_back.sv
rtl/box_point_metrics.sv
verif/box_point_metrics_test.sv
